### hw/rtl/fixed_point_to_decimal_text_top_assert.svh
// Assertion macros used by the back end of the fixed-point to decimal text converter.
`ifndef FIXED_POINT_TO_DECIMAL_TEXT_TOP_ASSERT_SVH
`define FIXED_POINT_TO_DECIMAL_TEXT_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FTD_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FTD_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

### hw/rtl/ftd_pkg.sv
// Package with the sizes, character codes and types of the decimal text block.
`timescale 1ns / 1ps
package ftd_pkg;

  localparam int VALUE_BITS     = 32;
  localparam int FRAC_BITS      = 6;
  localparam int DECIMAL_PLACES = 2;
  localparam int IN_BITS        = 32;

  // At least one integer bit is kept so the integer path always has a digit.
  localparam int INT_BITS = (VALUE_BITS > FRAC_BITS) ? (VALUE_BITS - FRAC_BITS) : 1;

  // Number of decimal digits needed for the largest integer part.
  function automatic int digits_for_bits(int bits);
    longint unsigned maxv;
    longint unsigned p;
    int n;
    maxv = (64'd1 << bits) - 64'd1;
    p = 64'd10;
    n = 1;
    for (int i = 0; i < 20; i++) begin
      if (p <= maxv) begin
        n++;
        p = p * 64'd10;
      end
    end
    return n;
  endfunction

  localparam int INT_DIGITS = digits_for_bits(INT_BITS);
  localparam int BCD_W      = 4 * INT_DIGITS;
  localparam int CNT_W      = $clog2(INT_BITS + 1);
  localparam int DIG_W      = $clog2(INT_DIGITS + 1);
  localparam int FL_W       = $clog2(DECIMAL_PLACES + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [6:0] CHAR_ZERO  = 7'd48;
  localparam logic [6:0] CHAR_COMMA = 7'd44;

  typedef struct packed {
    logic                is_zero;
    logic [INT_BITS-1:0] ipart;
    logic [FRAC_BITS-1:0] frac;
  } item_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CONV,
    B_INT,
    B_COMMA,
    B_FRAC
  } bstate_t;

endpackage

### hw/rtl/ftd_front.sv
// Front end: takes a word, splits it into integer and fraction parts and flags zero.
`timescale 1ns / 1ps
module ftd_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ftd_pkg::IN_BITS-1:0]    fixed_value,
  output logic                           push_valid,
  input  logic                           push_ready,
  output ftd_pkg::item_t                 push_item
);
  import ftd_pkg::*;

  logic [63:0] wide;
  logic [63:0] value_mask;
  item_t       item_next;
  item_t       hold;
  logic        hold_valid;

  // Only the low VALUE_BITS bits of the word take part.
  assign value_mask = (64'd1 << VALUE_BITS) - 64'd1;

  always_comb begin
    wide              = 64'(fixed_value) & value_mask;
    item_next.is_zero = (wide == 64'd0);
    // The integer part of the scaled value equals the integer part of the input.
    item_next.ipart   = INT_BITS'(wide >> FRAC_BITS);
    item_next.frac    = wide[FRAC_BITS-1:0];
  end

  assign in_ready   = !hold_valid || push_ready;
  assign push_valid = hold_valid;
  assign push_item  = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold <= item_next;
    end
  end

endmodule

### hw/rtl/ftd_queue.sv
// Short queue of classified words between the front end and the text generator.
`timescale 1ns / 1ps
module ftd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  ftd_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output ftd_pkg::item_t pop_item
);
  import ftd_pkg::*;

  item_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  function automatic logic [QPTR_W-1:0] ptr_inc(logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(p + 1'b1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= QCNT_W'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= QCNT_W'(count - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

### hw/rtl/ftd_back.sv
// Back end: bit-serial binary to BCD conversion and character output register.
`timescale 1ns / 1ps
`include "fixed_point_to_decimal_text_top_assert.svh"
module ftd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_ready,
  input  ftd_pkg::item_t q_item,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [6:0]     char_code,
  output logic           is_last
);
  import ftd_pkg::*;

  bstate_t                 state;
  bstate_t                 state_next;
  logic [INT_BITS-1:0]     sh;
  logic [BCD_W-1:0]        bcd;
  logic [BCD_W-1:0]        bcd_adj;
  logic [CNT_W-1:0]        cnt;
  logic [DIG_W-1:0]        dig_left;
  logic                    started;
  logic [FRAC_BITS-1:0]    frac;
  logic [FL_W-1:0]         frac_left;
  logic [FRAC_BITS+3:0]    prod;
  logic [3:0]              top_digit;
  logic                    out_free;
  logic                    int_skip;
  logic                    int_step;
  logic                    emit;
  logic [6:0]              emit_char;
  logic                    emit_last;

  assign out_free  = !out_valid || out_ready;
  assign top_digit = bcd[BCD_W-1 -: 4];
  assign prod      = (FRAC_BITS + 4)'(frac) * (FRAC_BITS + 4)'(4'd10);

  // Add-3 correction on every BCD digit before the next shift.
  always_comb begin
    for (int i = 0; i < INT_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? 4'(bcd[4*i +: 4] + 4'd3)
                                                  : bcd[4*i +: 4];
    end
  end

  // Leading zero digits are dropped, but the units digit always goes out.
  assign int_skip = !started && (top_digit == 4'd0) && (dig_left != DIG_W'(1));

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:  if (q_valid) state_next = B_CONV;
      B_CONV:  if (cnt == CNT_W'(1)) state_next = B_INT;
      B_INT:   if (int_step && dig_left == DIG_W'(1)) state_next = B_COMMA;
      B_COMMA: if (out_free) state_next = B_FRAC;
      B_FRAC:  if (out_free && frac_left == FL_W'(1)) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_ready   = 1'b0;
    int_step  = 1'b0;
    emit      = 1'b0;
    emit_char = CHAR_ZERO;
    emit_last = 1'b0;
    unique case (state)
      B_IDLE:  q_ready = 1'b1;
      B_CONV:  ;
      B_INT: begin
        int_step  = int_skip || out_free;
        emit      = !int_skip && out_free;
        emit_char = CHAR_ZERO + {3'b000, top_digit};
      end
      B_COMMA: begin
        emit      = out_free;
        emit_char = CHAR_COMMA;
      end
      B_FRAC: begin
        emit      = out_free;
        emit_char = CHAR_ZERO + {3'b000, prod[FRAC_BITS+3:FRAC_BITS]};
        emit_last = (frac_left == FL_W'(1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_free) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      char_code <= emit_char;
      is_last   <= emit_last;
    end
    unique case (state)
      B_IDLE: begin
        if (q_valid) begin
          sh        <= q_item.ipart;
          bcd       <= '0;
          cnt       <= CNT_W'(INT_BITS);
          dig_left  <= DIG_W'(INT_DIGITS);
          started   <= 1'b0;
          frac      <= q_item.frac;
          // Zero prints as a single fraction digit.
          frac_left <= q_item.is_zero ? FL_W'(1) : FL_W'(DECIMAL_PLACES);
        end
      end
      B_CONV: begin
        bcd <= BCD_W'({bcd_adj, sh[INT_BITS-1]});
        sh  <= INT_BITS'(sh << 1);
        cnt <= CNT_W'(cnt - 1'b1);
      end
      B_INT: begin
        if (int_step) begin
          bcd      <= BCD_W'(bcd << 4);
          dig_left <= DIG_W'(dig_left - 1'b1);
        end
        if (emit) begin
          started <= 1'b1;
        end
      end
      B_COMMA: ;
      B_FRAC: begin
        if (emit) begin
          frac      <= prod[FRAC_BITS-1:0];
          frac_left <= FL_W'(frac_left - 1'b1);
        end
      end
      default: ;
    endcase
  end

  `FTD_ASSERT_NOW(a_conv_count, state == B_CONV, cnt != '0, "conversion count ran out")
  `FTD_ASSERT_NOW(a_bcd_digit, state == B_INT, top_digit <= 4'd9, "BCD digit out of range")
  `FTD_ASSERT_NOW(a_last_frac, emit && emit_last, state == B_FRAC, "last flag off fraction")
  `FTD_ASSERT_NEXT(a_pop_conv, q_valid && q_ready, state == B_CONV, "pop did not start work")

endmodule

### hw/rtl/fixed_point_to_decimal_text_top.sv
// Top level of the fixed-point to decimal text converter.
`timescale 1ns / 1ps
// Each accepted word is an unsigned fixed-point number with FRAC_BITS fraction
// bits; the block sends out its text one ASCII character per transfer, most
// significant first: integer digits without leading zeros (a single '0' when
// the integer part is zero), a comma, then DECIMAL_PLACES truncated fraction
// digits, with is_last on the final character. Zero gives "0,0". In the back
// end a word goes through a one-bit-per-cycle binary to BCD shift loop over
// INT_BITS bits, then one step per integer digit position (waiting while the
// output is stalled for a digit that goes out), then the comma and the
// fraction digits. The front end and a two-word queue keep accepting words
// while the back end works, until they are full.
module fixed_point_to_decimal_text_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ftd_pkg::IN_BITS-1:0] fixed_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [6:0]                  char_code,
  output logic                        is_last
);
  import ftd_pkg::*;

  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  ftd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .fixed_value(fixed_value),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  ftd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_item (push_item),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_item  (q_item)
  );

  ftd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .char_code(char_code),
    .is_last  (is_last)
  );

endmodule

### dv/tb_fixed_point_to_decimal_text_top.sv
// Self-checking testbench for the fixed-point to decimal text converter.
`timescale 1ns / 1ps
module tb_fixed_point_to_decimal_text_top;
  import ftd_pkg::*;

  localparam int LIMIT_CYCLES    = 400_000;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int SETTLE_CYCLES   = 100;
  localparam int NUM_DIRECTED    = 22;

  localparam logic [IN_BITS-1:0] DIRECTED_WORDS [NUM_DIRECTED] = '{
    32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0004,
    32'h0000_0010, 32'h0000_0020, 32'h0000_003F, 32'h0000_0040,
    32'h0000_0041, 32'd576,       32'd640,       32'd6399,
    32'd6400,      32'd64000000,  32'h5555_5555, 32'hAAAA_AAAA,
    32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFC0, 32'hFFFF_FFFF,
    32'h0000_0000, 32'h0000_0001
  };

  typedef struct packed {
    logic [6:0] code;
    logic       last;
  } text_char_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [IN_BITS-1:0] fixed_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [6:0]         char_code;
  logic               is_last;

  logic [IN_BITS-1:0] pending_words[$];
  text_char_t         expected_chars[$];

  int  sender_idle_pct    = 0;
  int  receiver_stall_pct = 0;
  int  holds_requested    = 0;
  int  holds_served       = 0;
  int  hold_cycles_left   = 0;
  int  mismatch_count     = 0;
  int  cycle_count        = 0;
  bit  receiver_held;

  fixed_point_to_decimal_text_top uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .fixed_value(fixed_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .char_code  (char_code),
    .is_last    (is_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Scale by ten to the number of places, truncate, and spell out the text.
  task automatic predict_text(input logic [IN_BITS-1:0] word);
    longint unsigned value;
    longint unsigned scale;
    longint unsigned scaled;
    longint unsigned int_part;
    longint unsigned frac_part;
    logic [6:0]      text[$];
    logic [6:0]      frac_digits[DECIMAL_PLACES];
    text_char_t      entry;
    value = 64'(word) & ((64'd1 << VALUE_BITS) - 64'd1);
    if (value == 0) begin
      text.push_back(CHAR_ZERO);
      text.push_back(CHAR_COMMA);
      text.push_back(CHAR_ZERO);
    end else begin
      scale = 1;
      for (int i = 0; i < DECIMAL_PLACES; i++) scale = scale * 10;
      scaled    = (value * scale) >> FRAC_BITS;
      int_part  = scaled / scale;
      frac_part = scaled % scale;
      if (int_part == 0) begin
        text.push_back(CHAR_ZERO);
      end
      while (int_part != 0) begin
        text.push_front(CHAR_ZERO + 7'(int_part % 10));
        int_part = int_part / 10;
      end
      text.push_back(CHAR_COMMA);
      for (int i = DECIMAL_PLACES - 1; i >= 0; i--) begin
        frac_digits[i] = CHAR_ZERO + 7'(frac_part % 10);
        frac_part = frac_part / 10;
      end
      for (int i = 0; i < DECIMAL_PLACES; i++) text.push_back(frac_digits[i]);
    end
    foreach (text[i]) begin
      entry.code = text[i];
      entry.last = (i == text.size() - 1);
      expected_chars.push_back(entry);
    end
  endtask

  function automatic logic [IN_BITS-1:0] random_word();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom >> $urandom_range(0, 31);
      2: return $urandom_range(0, 255);
      3: return IN_BITS'($urandom_range(0, 99999)) << FRAC_BITS;
      4: return 32'hFFFF_FFFF - $urandom_range(0, 4095);
      default: return ($urandom_range(0, 9) == 0) ? '0 : $urandom_range(1, 63);
    endcase
  endfunction

  task automatic queue_words(input int count);
    for (int i = 0; i < count; i++) pending_words.push_back(random_word());
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid || expected_chars.size() != 0)
      @(negedge clk);
  endtask

  // Sender: a word is offered until accepted, then the next one or a gap.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_text(fixed_value);
      end
      if (!in_valid || in_ready) begin
        if (pending_words.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          in_valid    <= 1'b1;
          fixed_value <= pending_words.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, so the input queue fills and in_ready drops.
  always @(posedge clk) begin
    if (rst) begin
      hold_cycles_left <= 0;
    end else if (holds_served != holds_requested) begin
      hold_cycles_left <= HOLD_OFF_CYCLES;
      holds_served     <= holds_requested;
    end else if (hold_cycles_left != 0) begin
      hold_cycles_left <= hold_cycles_left - 1;
    end
  end

  assign receiver_held = (hold_cycles_left != 0);

  // Receiver: every accepted character is checked against the oldest expectation.
  always @(posedge clk) begin
    text_char_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected char_code=%0d is_last=%0b", $realtime, char_code,
                     is_last);
        end else begin
          want = expected_chars.pop_front();
          if (char_code !== want.code || is_last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: mismatch: expected char_code=%0d is_last=%0b, got %0d %0b",
                       $realtime, want.code, want.last, char_code, is_last);
          end
        end
      end
      out_ready <= !receiver_held && ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Corner values first, with both sides always ready.
    foreach (DIRECTED_WORDS[i]) pending_words.push_back(DIRECTED_WORDS[i]);
    wait_drained();

    queue_words(100);
    wait_drained();

    sender_idle_pct = 70;
    queue_words(100);
    wait_drained();

    sender_idle_pct    = 0;
    receiver_stall_pct = 70;
    queue_words(100);
    wait_drained();

    sender_idle_pct    = 11;
    receiver_stall_pct = 11;
    queue_words(100);
    wait_drained();

    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    holds_requested++;
    queue_words(30);
    wait_drained();

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && expected_chars.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/ftd_pkg.sv
hw/rtl/ftd_front.sv
hw/rtl/ftd_queue.sv
hw/rtl/ftd_back.sv
hw/rtl/fixed_point_to_decimal_text_top.sv
dv/tb_fixed_point_to_decimal_text_top.sv
